// ===== hw/rtl/vdq_pkg.sv =====
// Package for the value deque: operation and status codes, sequencer
// states and the result record shared by the controller and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vdq_pkg;

  localparam int OP_W   = 3;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 5;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_REMOVE     = 3'd4;
  localparam logic [OP_W-1:0] OP_SUB_MIN    = 3'd5;

  // status codes
  localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_MIN,
    S_SUB,
    S_FRONT,
    S_BACK,
    S_BACK_WAIT,
    S_DONE
  } state_t;

  // one result record
  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic [CNT_W-1:0]        entry_count;
    logic signed [VAL_W-1:0] front_value;
    logic signed [VAL_W-1:0] back_value;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/vdq_if.sv =====
// Valid/ready channel interfaces for the value deque: operation input
// and result output. Depends on vdq_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface vdq_in_if;
  import vdq_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic signed [VAL_W-1:0] item_value;

  modport source (output valid, output operation, output item_value, input ready);
  modport sink   (input valid, input operation, input item_value, output ready);
endinterface

interface vdq_out_if;
  import vdq_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [STAT_W-1:0]       status;
  logic [CNT_W-1:0]        entry_count;
  logic signed [VAL_W-1:0] front_value;
  logic signed [VAL_W-1:0] back_value;

  modport source (output valid, output status, output entry_count,
                  output front_value, output back_value, input ready);
  modport sink   (input valid, input status, input entry_count,
                  input front_value, input back_value, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/value_deque_with_remove_and_rebase_top.sv =====
// Top level of the value deque: entry memory, sequencer and result
// register. Depends on vdq_pkg, vdq_if, vdq_ram and vdq_ctrl.
//
//   channel   dir   payload                                        flow
//   in_ch     in    operation, item_value                          valid/ready
//   out_ch    out   status, entry_count, front_value, back_value   valid/ready
//
// One operation at a time. Push and pop read the front and then the back
// entry before the result (both ends report zero when the list ends up
// empty); remove and subtract-minimum first walk the entries, paced by the
// single read port of the entry memory, one entry per cycle.
// Reset clears state, pointers, count and valid flags; the memory needs no clearing.
// The result register frees the sequencer: a new operation is taken while
// a result waits, and the sequencer holds its next result until the
// register drains.
`timescale 1ns / 1ps
`default_nettype none

module value_deque_with_remove_and_rebase_top #(
  parameter int DEPTH = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  vdq_in_if.sink     in_ch,
  vdq_out_if.source  out_ch
);

  import vdq_pkg::*;

  localparam int IW = $clog2(DEPTH);

  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic [IW-1:0] mem_raddr;
  logic [31:0]   mem_rdata;

  logic res_valid;
  logic res_ready;
  res_t res;

  res_t out_r;
  logic out_valid_r;

  // entry memory
  vdq_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // sequencer
  vdq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // result register
  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_r.status;
  assign out_ch.entry_count = out_r.entry_count;
  assign out_ch.front_value = out_r.front_value;
  assign out_ch.back_value  = out_r.back_value;

  // an empty list reports zero at both ends
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.entry_count == '0) |->
      (out_r.front_value == '0 && out_r.back_value == '0))
    else $error("empty result with nonzero end values");

  // a refused push only happens on a full list
  assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.status == ST_FULL) |-> (res.entry_count == CNT_W'(DEPTH)))
    else $error("full status with count below depth");

  // an empty status leaves nothing held
  assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.status == ST_EMPTY) |-> (res.entry_count == '0))
    else $error("empty status with entries held");

  // a held result from the sequencer does not change
  assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_ready) |=> (res_valid && $stable(res)))
    else $error("sequencer result changed while held");

endmodule

`default_nettype wire

// ===== hw/rtl/vdq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module vdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hw/rtl/vdq_ctrl.sv =====
// Sequencer of the value deque: ring pointers, operation decode and the
// walks over the entry memory for remove and subtract-minimum.
// Depends on vdq_pkg and vdq_in_if; drives an external vdq_ram.
`timescale 1ns / 1ps
`default_nettype none

module vdq_ctrl #(
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  vdq_in_if.sink                        in_ch,
  output      logic                     res_valid,
  input  wire logic                     res_ready,
  output      vdq_pkg::res_t            res,
  output      logic                     mem_we,
  output      logic [$clog2(DEPTH)-1:0] mem_waddr,
  output      logic [31:0]              mem_wdata,
  output      logic [$clog2(DEPTH)-1:0] mem_raddr,
  input  wire logic [31:0]              mem_rdata
);

  import vdq_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // ring slot of a position counted from the front
  function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] base,
                                            input logic [CW-1:0] pos);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(pos);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return sum[IW-1:0];
  endfunction

  state_t            state_r, state_nxt;
  logic [IW-1:0]     front_r, front_nxt;
  logic [CW-1:0]     occ_r, occ_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [VAL_W-1:0]  mn_r, mn_nxt;
  logic [VAL_W-1:0]  fv_r, fv_nxt;
  logic [VAL_W-1:0]  bv_r, bv_nxt;
  logic [CW-1:0]     rd_i_r, rd_i_nxt;
  logic [IW-1:0]     di_r, di_nxt;
  logic              dv_r, dv_nxt;

  logic          accept;
  logic          full;
  logic          empty;
  logic          walk_end;
  logic          last;
  logic          hit;
  logic          less;
  logic [IW-1:0] front_dec;
  logic [IW-1:0] front_inc;

  // input handshake: one operation at a time
  assign in_ch.ready = (state_r == S_IDLE);

  // shared conditions
  assign accept    = in_ch.valid && in_ch.ready;
  assign full      = (occ_r == CW'(DEPTH));
  assign empty     = (occ_r == '0);
  assign walk_end  = (rd_i_r >= occ_r);
  assign last      = dv_r && (CW'(di_r) == (occ_r - CW'(1)));
  assign hit       = dv_r && (mem_rdata == val_r);
  assign less      = ($signed(mem_rdata) < $signed(mn_r));
  assign front_dec = (front_r == '0) ? IW'(DEPTH - 1) : (front_r - IW'(1));
  assign front_inc = (front_r == IW'(DEPTH - 1)) ? '0 : (front_r + IW'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_ch.operation == OP_REMOVE && !empty) begin
            state_nxt = S_SCAN;
          end else if (in_ch.operation == OP_SUB_MIN && !empty) begin
            state_nxt = S_MIN;
          end else begin
            state_nxt = S_FRONT;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_nxt = S_SHIFT;
        end else if (last) begin
          state_nxt = S_FRONT;
        end
      end
      S_SHIFT: begin
        if (walk_end) begin
          state_nxt = S_FRONT;
        end
      end
      S_MIN: begin
        if (last) begin
          state_nxt = S_SUB;
        end
      end
      S_SUB: begin
        if (walk_end) begin
          state_nxt = S_FRONT;
        end
      end
      S_FRONT: begin
        state_nxt = empty ? S_DONE : S_BACK;
      end
      S_BACK: begin
        state_nxt = S_BACK_WAIT;
      end
      S_BACK_WAIT: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result handshake and memory port outputs
  always_comb begin
    res_valid   = (state_r == S_DONE);
    mem_we      = 1'b0;
    mem_waddr   = slot_of(front_r, occ_r);
    mem_wdata   = in_ch.item_value;
    mem_raddr   = slot_of(front_r, rd_i_r);
    unique case (state_r)
      S_IDLE: begin
        if (accept && !full) begin
          if (in_ch.operation == OP_PUSH_FRONT) begin
            mem_we    = 1'b1;
            mem_waddr = front_dec;
          end else if (in_ch.operation == OP_PUSH_BACK) begin
            mem_we    = 1'b1;
          end
        end
      end
      S_SHIFT: begin
        // close up: entry read at position i lands at position i-1
        mem_we    = dv_r;
        mem_waddr = slot_of(front_r, CW'(di_r) - CW'(1));
        mem_wdata = mem_rdata;
      end
      S_SUB: begin
        mem_we    = dv_r;
        mem_waddr = slot_of(front_r, CW'(di_r));
        mem_wdata = mem_rdata - mn_r;
      end
      S_FRONT: begin
        mem_raddr = front_r;
      end
      S_BACK: begin
        mem_raddr = slot_of(front_r, occ_r - CW'(1));
      end
      default: begin
      end
    endcase
  end

  // datapath next values
  always_comb begin
    front_nxt  = front_r;
    occ_nxt    = occ_r;
    val_nxt    = val_r;
    status_nxt = status_r;
    mn_nxt     = mn_r;
    fv_nxt     = fv_r;
    bv_nxt     = bv_r;
    rd_i_nxt   = rd_i_r;
    di_nxt     = di_r;
    dv_nxt     = 1'b0;

    // walk: one read issued per cycle, its data used in the cycle after
    if (state_r == S_SCAN || state_r == S_SHIFT || state_r == S_MIN ||
        state_r == S_SUB) begin
      if (!walk_end) begin
        rd_i_nxt = rd_i_r + CW'(1);
        di_nxt   = rd_i_r[IW-1:0];
        dv_nxt   = 1'b1;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          val_nxt    = in_ch.item_value;
          status_nxt = ST_DONE;
          rd_i_nxt   = '0;
          dv_nxt     = 1'b0;
          if (in_ch.operation == OP_PUSH_FRONT || in_ch.operation == OP_PUSH_BACK) begin
            if (full) begin
              status_nxt = ST_FULL;
            end else begin
              occ_nxt = occ_r + CW'(1);
              if (in_ch.operation == OP_PUSH_FRONT) begin
                front_nxt = front_dec;
              end
            end
          end else if (in_ch.operation == OP_POP_FRONT ||
                       in_ch.operation == OP_POP_BACK) begin
            if (empty) begin
              status_nxt = ST_EMPTY;
            end else begin
              occ_nxt = occ_r - CW'(1);
              if (in_ch.operation == OP_POP_FRONT) begin
                front_nxt = front_inc;
              end
            end
          end else if (in_ch.operation == OP_REMOVE ||
                       in_ch.operation == OP_SUB_MIN) begin
            if (empty) begin
              status_nxt = ST_EMPTY;
            end
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          // restart the walk just past the match
          rd_i_nxt = CW'(di_r) + CW'(1);
          dv_nxt   = 1'b0;
        end else if (last) begin
          status_nxt = ST_NOT_FOUND;
        end
      end
      S_SHIFT: begin
        if (walk_end) begin
          occ_nxt = occ_r - CW'(1);
        end
      end
      S_MIN: begin
        if (dv_r && (di_r == '0 || less)) begin
          mn_nxt = mem_rdata;
        end
        if (last) begin
          rd_i_nxt = '0;
          dv_nxt   = 1'b0;
        end
      end
      S_FRONT: begin
        if (empty) begin
          fv_nxt = '0;
          bv_nxt = '0;
        end
      end
      S_BACK: begin
        fv_nxt = mem_rdata;
      end
      S_BACK_WAIT: begin
        bv_nxt = mem_rdata;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      front_r <= '0;
      occ_r   <= '0;
      dv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      occ_r   <= occ_nxt;
      dv_r    <= dv_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    val_r    <= val_nxt;
    status_r <= status_nxt;
    mn_r     <= mn_nxt;
    fv_r     <= fv_nxt;
    bv_r     <= bv_nxt;
    rd_i_r   <= rd_i_nxt;
    di_r     <= di_nxt;
  end

  // result record
  always_comb begin
    res.status      = status_r;
    res.entry_count = CNT_W'(occ_r);
    res.front_value = fv_r;
    res.back_value  = bv_r;
  end

endmodule

`default_nettype wire
